FILE: hw/rtl/psv_pkg.sv
// shared types and constants for the path syntax validator
// byte classes, scan state encodings, status codes and queue sizing
// no dependencies
package psv_pkg;

    // default number of entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // path phase
    typedef enum logic [1:0] {
        PH_INIT  = 2'd0,
        PH_DRIVE = 2'd1,
        PH_SEP   = 2'd2,
        PH_ELEM  = 2'd3
    } phase_t;

    // lookahead mode
    typedef enum logic [2:0] {
        MD_START   = 3'd0,
        MD_LETTER  = 3'd1,
        MD_DOT     = 3'd2,
        MD_DOTDOT  = 3'd3,
        MD_STAR    = 3'd4,
        MD_NAME    = 3'd5,
        MD_SWALLOW = 3'd6
    } mode_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_DRIVE     = 3'd2,
        ST_SEPARATOR = 3'd3,
        ST_ELEMENT   = 3'd4,
        ST_TRAIL     = 3'd5
    } status_t;

    // byte classes produced by the front
    typedef enum logic [3:0] {
        CL_TERM      = 4'd0,
        CL_SLASH     = 4'd1,
        CL_BACKSLASH = 4'd2,
        CL_COLON     = 4'd3,
        CL_DOT       = 4'd4,
        CL_STAR      = 4'd5,
        CL_LETTER    = 4'd6,
        CL_CTL       = 4'd7,
        CL_OTHER     = 4'd8
    } cls_t;

    // character constants
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_DEL       = 8'h7F;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // queue head as seen by the back
    typedef struct packed {
        logic valid;
        cls_t cls;
    } queue_head_t;

endpackage

FILE: hw/rtl/psv_front.sv
// front of the path syntax validator: accepts bytes, classifies them
// and holds the classes in a short queue for the back
// depends on psv_pkg
module psv_front #(
    parameter int DEPTH = psv_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            ch,
    output psv_pkg::queue_head_t  head,
    input  logic                  pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    psv_pkg::cls_t    queue_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    psv_pkg::cls_t    cls_in;
    logic             push;
    logic             do_pop;

    // byte classification
    always_comb
    begin
        if (ch == 8'h00)
            cls_in = psv_pkg::CL_TERM;
        else if (ch == psv_pkg::CH_SLASH)
            cls_in = psv_pkg::CL_SLASH;
        else if (ch == psv_pkg::CH_BACKSLASH)
            cls_in = psv_pkg::CL_BACKSLASH;
        else if (ch == psv_pkg::CH_COLON)
            cls_in = psv_pkg::CL_COLON;
        else if (ch == psv_pkg::CH_DOT)
            cls_in = psv_pkg::CL_DOT;
        else if (ch == psv_pkg::CH_STAR)
            cls_in = psv_pkg::CL_STAR;
        else if (ch inside {[8'h41:8'h5A], [8'h61:8'h7A]})
            cls_in = psv_pkg::CL_LETTER;
        else if (ch < psv_pkg::CH_SPACE || ch == psv_pkg::CH_DEL)
            cls_in = psv_pkg::CL_CTL;
        else
            cls_in = psv_pkg::CL_OTHER;
    end

    // queue control
    assign in_stall   = (count_reg == FULL_CNT);
    assign push       = in_valid && !in_stall;
    assign head.valid = (count_reg != '0);
    assign head.cls   = queue_mem[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_ONE;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_ONE;
        if (push && !do_pop)
            count_next = count_reg + CNT_ONE;
        else if (do_pop && !push)
            count_next = count_reg - CNT_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            queue_mem[wr_ptr_reg] <= cls_in;
    end

endmodule

FILE: hw/rtl/psv_back.sv
// back of the path syntax validator: runs the path scanner on classified
// bytes and holds the status word in an output register
// depends on psv_pkg
module psv_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  psv_pkg::queue_head_t head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           status
);

    typedef struct packed {
        psv_pkg::phase_t  phase;
        psv_pkg::mode_t   mode;
        logic [1:0]       tally;
        psv_pkg::status_t err;
        logic             seen;
    } scan_t;

    localparam scan_t SCAN_CLEAR = '{
        phase: psv_pkg::PH_INIT,
        mode:  psv_pkg::MD_START,
        tally: 2'd0,
        err:   psv_pkg::ST_OK,
        seen:  1'b0
    };

    scan_t            scan_reg;
    scan_t            scan_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    psv_pkg::status_t status_reg;
    psv_pkg::status_t status_next;
    logic             is_term;

    function automatic logic is_sep(input psv_pkg::cls_t c);
        return (c == psv_pkg::CL_SLASH) || (c == psv_pkg::CL_BACKSLASH);
    endfunction

    // record the first error only
    function automatic scan_t fail(input scan_t s, input psv_pkg::status_t code);
        scan_t r;
        r = s;
        if (r.err == psv_pkg::ST_OK)
            r.err = code;
        return r;
    endfunction

    // element token: rejected right after another element
    function automatic scan_t take_elem(input scan_t s);
        scan_t r;
        r = s;
        if (r.phase == psv_pkg::PH_ELEM)
            r = fail(r, psv_pkg::ST_ELEMENT);
        else
            r.phase = psv_pkg::PH_ELEM;
        return r;
    endfunction

    function automatic scan_t token_start(input scan_t s, input psv_pkg::cls_t c);
        scan_t r;
        r = s;
        r.mode = psv_pkg::MD_START;
        if (is_sep(c))
        begin
            if (r.phase == psv_pkg::PH_SEP)
                r = fail(r, psv_pkg::ST_SEPARATOR);
            else
            begin
                if (r.phase == psv_pkg::PH_INIT)
                    r.mode = psv_pkg::MD_SWALLOW;
                r.phase = psv_pkg::PH_SEP;
                if (r.tally < 2'd2)
                    r.tally = r.tally + 2'd1;
            end
        end
        else if (c == psv_pkg::CL_LETTER)
            r.mode = psv_pkg::MD_LETTER;
        else if (c == psv_pkg::CL_DOT)
            r.mode = psv_pkg::MD_DOT;
        else if (c == psv_pkg::CL_STAR)
            r.mode = psv_pkg::MD_STAR;
        else if (c == psv_pkg::CL_CTL)
            r = fail(r, psv_pkg::ST_ELEMENT);
        else if (r.phase == psv_pkg::PH_ELEM)
            r = fail(r, psv_pkg::ST_ELEMENT);
        else
        begin
            r.phase = psv_pkg::PH_ELEM;
            r.mode  = psv_pkg::MD_NAME;
        end
        return r;
    endfunction

    // byte inside an accepted name
    function automatic scan_t name_byte(input scan_t s, input psv_pkg::cls_t c);
        scan_t r;
        r = s;
        if (is_sep(c))
            r = token_start(r, c);
        else if (c == psv_pkg::CL_CTL)
            r = fail(r, psv_pkg::ST_ELEMENT);
        else
            r.mode = psv_pkg::MD_NAME;
        return r;
    endfunction

    // pending bytes turn into a name
    function automatic scan_t name_pending(input scan_t s, input psv_pkg::cls_t c);
        scan_t r;
        r = s;
        if (r.phase == psv_pkg::PH_ELEM)
            r = fail(r, psv_pkg::ST_ELEMENT);
        else
        begin
            r.phase = psv_pkg::PH_ELEM;
            r = name_byte(r, c);
        end
        return r;
    endfunction

    // dot or dot-dot closed by a separator
    function automatic scan_t dots_sep(input scan_t s, input psv_pkg::cls_t c);
        scan_t r;
        r = s;
        if (r.phase == psv_pkg::PH_ELEM)
            r = fail(r, psv_pkg::ST_ELEMENT);
        else
        begin
            r.phase = psv_pkg::PH_ELEM;
            r = token_start(r, c);
        end
        return r;
    endfunction

    // one non-terminator byte
    function automatic scan_t step_byte(input scan_t s, input psv_pkg::cls_t c);
        scan_t r;
        r = s;
        r.seen = 1'b1;
        if (r.err == psv_pkg::ST_OK)
        begin
            case (r.mode)
                psv_pkg::MD_LETTER:
                begin
                    if (c == psv_pkg::CL_COLON)
                    begin
                        r.mode = psv_pkg::MD_START;
                        if (r.phase == psv_pkg::PH_INIT)
                            r.phase = psv_pkg::PH_DRIVE;
                        else
                            r = fail(r, psv_pkg::ST_DRIVE);
                    end
                    else
                        r = name_pending(r, c);
                end
                psv_pkg::MD_DOT:
                begin
                    if (is_sep(c))
                        r = dots_sep(r, c);
                    else if (c == psv_pkg::CL_DOT)
                        r.mode = psv_pkg::MD_DOTDOT;
                    else
                        r = name_pending(r, c);
                end
                psv_pkg::MD_DOTDOT:
                begin
                    if (is_sep(c))
                        r = dots_sep(r, c);
                    else
                        r = name_pending(r, c);
                end
                psv_pkg::MD_STAR:
                begin
                    if (c == psv_pkg::CL_STAR)
                    begin
                        r.mode = psv_pkg::MD_START;
                        r = take_elem(r);
                    end
                    else
                        r = name_pending(r, c);
                end
                psv_pkg::MD_NAME:
                    r = name_byte(r, c);
                psv_pkg::MD_SWALLOW:
                begin
                    if (c == psv_pkg::CL_BACKSLASH)
                        r.mode = psv_pkg::MD_START;
                    else
                        r = token_start(r, c);
                end
                default:
                    r = token_start(r, c);
            endcase
        end
        return r;
    endfunction

    // status at the terminator
    function automatic psv_pkg::status_t finish(input scan_t s);
        scan_t            r;
        psv_pkg::status_t st;
        r = s;
        if (r.err == psv_pkg::ST_OK && (r.mode inside {psv_pkg::MD_LETTER,
            psv_pkg::MD_DOT, psv_pkg::MD_DOTDOT, psv_pkg::MD_STAR}))
            r = take_elem(r);
        if (r.err != psv_pkg::ST_OK)
            st = r.err;
        else if (!r.seen)
            st = psv_pkg::ST_EMPTY;
        else if (r.phase == psv_pkg::PH_SEP && r.tally > 2'd1)
            st = psv_pkg::ST_TRAIL;
        else
            st = psv_pkg::ST_OK;
        return st;
    endfunction

    // take a word unless a terminator would overrun a held status
    assign is_term   = (head.cls == psv_pkg::CL_TERM);
    assign pop       = head.valid && (!is_term || !out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;

    // scanner and output register next values
    always_comb
    begin
        scan_next      = scan_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        if (pop)
        begin
            if (is_term)
            begin
                status_next    = finish(scan_reg);
                out_valid_next = 1'b1;
                scan_next      = SCAN_CLEAR;
            end
            else
                scan_next = step_byte(scan_reg, head.cls);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg      <= SCAN_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // status payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

endmodule

FILE: hw/rtl/path_syntax_validator_core.sv
// Path syntax validator: takes a file path one byte a cycle on ch while in_stall
// is low, a zero byte ending each path, and returns one 3-bit status word per path
// (0 ok, 1 empty, 2 drive misplaced, 3 doubled separator, 4 bad element, 5 trailing
// separator). Sustained rate is one byte per cycle while nothing stalls; it is set
// by the back scanner, which updates its state as each byte is popped. A status
// reaches the output register once the back pops its terminator from the byte
// queue; the byte queue (DEPTH entries) lets input continue while a status waits.
// top level: instantiates psv_front and psv_back, depends on psv_pkg
module path_syntax_validator_core #(
    parameter int DEPTH = psv_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] ch,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] status
);

    psv_pkg::queue_head_t head;
    logic                 pop;

    // byte intake and classification
    psv_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .ch       (ch),
        .head     (head),
        .pop      (pop)
    );

    // path scanner and status output
    psv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status)
    );

endmodule
